### rtl/rtf_pkg.sv
// rtf_pkg: shared widths, character codes and helper functions for the
// rich-text to plain-text filter; no dependencies

package rtf_pkg;

  localparam int CHAR_W  = 16;
  localparam int HEX_W   = 8;
  localparam int NIB_W   = 4;
  localparam int MATCH_W = 3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_APOS      = 16'h0027;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_CR        = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_LF        = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_LBRACE    = 16'h007B;
  localparam logic [CHAR_W-1:0] CH_RBRACE    = 16'h007D;

  // escape phase codes
  localparam logic [1:0] ESC_NONE   = 2'd0;
  localparam logic [1:0] ESC_FIRST  = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  // ansi match positions
  localparam logic [MATCH_W-1:0] POS_NONE  = 3'd0;
  localparam logic [MATCH_W-1:0] POS_BSL   = 3'd1;
  localparam logic [MATCH_W-1:0] POS_LAST  = 3'd4;

  typedef struct packed {
    logic             ok;
    logic [NIB_W-1:0] val;
  } hex_digit_t;

  // ascii hex digit decode
  function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_digit_t h;
    h.ok  = 1'b0;
    h.val = '0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      h.ok  = 1'b1;
      h.val = NIB_W'(c - 16'h0030);
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      h.ok  = 1'b1;
      h.val = NIB_W'(c - 16'h0061 + 16'd10);
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      h.ok  = 1'b1;
      h.val = NIB_W'(c - 16'h0041 + 16'd10);
    end
    return h;
  endfunction

  // letter of "ansi" expected at a match position
  function automatic logic [CHAR_W-1:0] ansi_letter(input logic [MATCH_W-1:0] pos);
    logic [CHAR_W-1:0] l;
    unique case (pos)
      3'd1:    l = 16'h0061;
      3'd2:    l = 16'h006E;
      3'd3:    l = 16'h0073;
      3'd4:    l = 16'h0069;
      default: l = 16'h0000;
    endcase
    return l;
  endfunction

endpackage

### rtl/rtf_in_if.sv
// rtf_in_if: input channel carrying one rich-text word per handshake
// depends on rtf_pkg

interface rtf_in_if;
  import rtf_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_of_text;
  logic [CHAR_W-1:0] in_char;

  modport source (output valid, output start_of_text, output in_char, input ready);
  modport sink   (input valid, input start_of_text, input in_char, output ready);
endinterface

### rtl/rtf_out_if.sv
// rtf_out_if: output channel carrying one plain-text word per handshake
// depends on rtf_pkg

interface rtf_out_if;
  import rtf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;

  modport source (output valid, output out_char, input ready);
  modport sink   (input valid, input out_char, output ready);
endinterface

### rtl/rtf_plain_text_filter_top.sv
// rtf_plain_text_filter_top: rich-text to plain-text character filter
// depends on rtf_pkg, rtf_in_if, rtf_out_if
//
// usage:
//   in_ch takes one 16-bit code unit of rich text per word; start_of_text
//   set on a word clears all parse state before that word is handled.
//   out_ch gives zero or one plain-text code unit per input word, in order.
//   control words, brace regions and leading blanks are dropped; after the
//   control word "ansi", backslash-apostrophe plus two hex digits emits
//   that code.
// timing:
//   one word per cycle sustained while out_ch takes its words. a word is
//   filtered while it sits in the input register and then lands in the
//   output register, from which it shows on out_ch.
// reset:
//   rst (synchronous) empties both registers and clears all parse state.
// stall:
//   the input register and output register advance together; while out_ch
//   is stalled with a word held, in_ch still takes one word into an empty
//   input register, then deasserts ready until out_ch drains.

module rtf_plain_text_filter_top (
  input logic      clk,
  input logic      rst,
  rtf_in_if.sink   in_ch,
  rtf_out_if.source out_ch
);
  import rtf_pkg::*;

  // input register
  logic              s1_valid;
  logic              s1_start;
  logic [CHAR_W-1:0] s1_char;

  // parse state
  logic               in_control_word, in_control_word_next;
  logic               in_brace_region, in_brace_region_next;
  logic               ansi_mode,       ansi_mode_next;
  logic               text_begun,      text_begun_next;
  logic [MATCH_W-1:0] ansi_match_pos,  ansi_match_pos_next;
  logic [1:0]         escape_phase,    escape_phase_next;
  logic [HEX_W-1:0]   hex_accum,       hex_accum_next;
  logic               hex_stopped,     hex_stopped_next;

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;

  logic              advance;
  logic              emit;
  logic [CHAR_W-1:0] result;

  // effective state after optional start-of-text clear
  logic               st_cw, st_brace, st_ansi, st_begun, st_stopped;
  logic [MATCH_W-1:0] st_pos, pos;
  logic [1:0]         st_esc;
  logic [HEX_W-1:0]   st_accum;
  hex_digit_t         hd;
  logic               drop;

  assign advance      = !out_valid || out_ch.ready;
  assign in_ch.ready  = !s1_valid || advance;
  assign out_ch.valid = out_valid;
  assign out_ch.out_char = out_char;

  // filter logic for the word in the input register
  always_comb begin
    st_cw      = s1_start ? 1'b0 : in_control_word;
    st_brace   = s1_start ? 1'b0 : in_brace_region;
    st_ansi    = s1_start ? 1'b0 : ansi_mode;
    st_begun   = s1_start ? 1'b0 : text_begun;
    st_pos     = s1_start ? POS_NONE : ansi_match_pos;
    st_esc     = s1_start ? ESC_NONE : escape_phase;
    st_accum   = s1_start ? '0 : hex_accum;
    st_stopped = s1_start ? 1'b0 : hex_stopped;

    in_control_word_next = st_cw;
    in_brace_region_next = st_brace;
    ansi_mode_next       = st_ansi;
    text_begun_next      = st_begun;
    ansi_match_pos_next  = st_pos;
    escape_phase_next    = st_esc;
    hex_accum_next       = st_accum;
    hex_stopped_next     = st_stopped;

    hd     = hex_decode(s1_char);
    emit   = 1'b0;
    result = s1_char;
    drop   = 1'b0;
    pos    = (st_pos > POS_LAST) ? POS_NONE : st_pos;

    priority if (st_esc == ESC_FIRST) begin
      // first hex digit
      hex_accum_next    = hd.ok ? {{(HEX_W-NIB_W){1'b0}}, hd.val} : '0;
      hex_stopped_next  = !hd.ok;
      escape_phase_next = ESC_SECOND;
    end else if (st_esc == ESC_SECOND) begin
      // second hex digit, emit the code
      if (!st_stopped && hd.ok) begin
        hex_accum_next = {st_accum[NIB_W-1:0], hd.val};
      end
      escape_phase_next    = ESC_NONE;
      in_control_word_next = 1'b0;
      emit                 = 1'b1;
      result               = {{(CHAR_W-HEX_W){1'b0}}, hex_accum_next};
    end else begin
      escape_phase_next   = ESC_NONE;
      ansi_match_pos_next = POS_NONE;
      priority if (pos == POS_BSL && s1_char == CH_APOS && st_ansi) begin
        // hex escape opens
        escape_phase_next = ESC_FIRST;
        hex_accum_next    = '0;
        hex_stopped_next  = 1'b0;
      end else if (s1_char == CH_BACKSLASH) begin
        in_control_word_next = 1'b1;
        ansi_match_pos_next  = POS_BSL;
      end else begin
        // track the "ansi" control word
        if (pos != POS_NONE && s1_char == ansi_letter(pos)) begin
          if (pos == POS_LAST) begin
            ansi_mode_next = 1'b1;
          end else begin
            ansi_match_pos_next = pos + 3'd1;
          end
        end
        // delimiters
        priority if (s1_char == CH_SPACE || s1_char == CH_CR || s1_char == CH_LF) begin
          in_control_word_next = 1'b0;
          drop                 = !st_begun;
        end else if (s1_char == CH_LBRACE) begin
          in_brace_region_next = 1'b1;
          in_control_word_next = 1'b0;
          drop                 = 1'b1;
        end else if (s1_char == CH_RBRACE) begin
          in_brace_region_next = 1'b0;
          in_control_word_next = 1'b0;
          drop                 = 1'b1;
        end else begin
          drop = 1'b0;
        end
        if (!drop && !in_control_word_next && !in_brace_region_next) begin
          text_begun_next = 1'b1;
          emit            = 1'b1;
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready) begin
      s1_start <= in_ch.start_of_text;
      s1_char  <= in_ch.in_char;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_control_word <= 1'b0;
      in_brace_region <= 1'b0;
      ansi_mode       <= 1'b0;
      text_begun      <= 1'b0;
      ansi_match_pos  <= POS_NONE;
      escape_phase    <= ESC_NONE;
      hex_accum       <= '0;
      hex_stopped     <= 1'b0;
    end else if (advance && s1_valid) begin
      in_control_word <= in_control_word_next;
      in_brace_region <= in_brace_region_next;
      ansi_mode       <= ansi_mode_next;
      text_begun      <= text_begun_next;
      ansi_match_pos  <= ansi_match_pos_next;
      escape_phase    <= escape_phase_next;
      hex_accum       <= hex_accum_next;
      hex_stopped     <= hex_stopped_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && emit;
    end
    if (advance) begin
      out_char <= result;
    end
  end

  // closing an escape always produces a word
  a_escape_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && !s1_start && escape_phase == ESC_SECOND) |=> out_valid)
    else $error("escape end did not emit a word");

  // text_begun only drops on a new text
  a_begun_cleared: assert property (@(posedge clk) disable iff (rst)
    $fell(text_begun) |-> $past(s1_valid && s1_start))
    else $error("text_begun cleared without start_of_text");

  // input stalls only with both registers full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && out_valid))
    else $error("input stalled with a free register");

endmodule

### sim/rtf_filter_checker.sv
// rtf_filter_checker: watches both channels of the rich-text filter, predicts
// each plain-text word and compares it with what the block gives
// depends on rtf_pkg, rtf_in_if, rtf_out_if

module rtf_filter_checker
  import rtf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rtf_in_if    in_ch,
  rtf_out_if   out_ch,
  output int   errors,
  output int   pending,
  output int   words_seen,
  output int   chars_checked,
  output int   escapes_emitted
);

  typedef struct packed {
    logic               ctl;
    logic               brace;
    logic               ansi;
    logic               begun;
    logic [MATCH_W-1:0] match;
    logic [1:0]         esc;
    logic [HEX_W-1:0]   acc;
    logic               stopped;
  } parse_state_t;

  // letters of the control word that turns on hex escapes
  localparam logic [CHAR_W-1:0] ANSI_WORD [4] = '{16'h0061, 16'h006E, 16'h0073, 16'h0069};

  parse_state_t           st;
  logic [CHAR_W-1:0]      expected_chars [$];

  // ascii hex digit value, -1 for anything else
  function automatic int hex_nibble(input logic [CHAR_W-1:0] c);
    if (c >= 16'h0030 && c <= 16'h0039) return int'(c) - 'h30;
    if (c >= 16'h0061 && c <= 16'h0066) return int'(c) - 'h61 + 10;
    if (c >= 16'h0041 && c <= 16'h0046) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // advance the parse state by one word and work out the plain-text word, if any
  task automatic filter_word(input logic sot, input logic [CHAR_W-1:0] c,
                             output logic emit, output logic by_escape,
                             output logic [CHAR_W-1:0] code);
    int                 hv;
    logic [MATCH_W-1:0] pos;
    emit      = 1'b0;
    by_escape = 1'b0;
    code      = '0;
    if (sot) st = '0;
    hv = hex_nibble(c);

    // the two characters after backslash-apostrophe
    if (st.esc == ESC_FIRST) begin
      if (hv < 0) begin
        st.acc     = '0;
        st.stopped = 1'b1;
      end else begin
        st.acc     = HEX_W'(hv);
        st.stopped = 1'b0;
      end
      st.esc = ESC_SECOND;
      return;
    end
    if (st.esc == ESC_SECOND) begin
      if (!st.stopped && hv >= 0) st.acc = {st.acc[3:0], 4'(hv)};
      st.esc    = ESC_NONE;
      st.ctl    = 1'b0;
      emit      = 1'b1;
      by_escape = 1'b1;
      code      = CHAR_W'(st.acc);
      return;
    end
    st.esc = ESC_NONE;

    pos      = (st.match > POS_LAST) ? POS_NONE : st.match;
    st.match = POS_NONE;

    // apostrophe right after a backslash opens an escape once ansi is on
    if (pos == POS_BSL && c == CH_APOS && st.ansi) begin
      st.esc     = ESC_FIRST;
      st.acc     = '0;
      st.stopped = 1'b0;
      return;
    end
    if (c == CH_BACKSLASH) begin
      st.ctl   = 1'b1;
      st.match = POS_BSL;
      return;
    end

    // track the letters of "ansi" after a backslash
    if (pos != POS_NONE && c == ANSI_WORD[2'(pos - 3'd1)]) begin
      if (pos == POS_LAST) st.ansi = 1'b1;
      else st.match = pos + 3'd1;
    end

    // blanks end control words and are dropped before the text begins
    if (c == CH_SPACE || c == CH_CR || c == CH_LF) begin
      st.ctl = 1'b0;
      if (!st.begun) return;
    end else if (c == CH_LBRACE) begin
      st.brace = 1'b1;
      st.ctl   = 1'b0;
      return;
    end else if (c == CH_RBRACE) begin
      st.ctl   = 1'b0;
      st.brace = 1'b0;
      return;
    end

    if (!st.ctl && !st.brace) begin
      st.begun = 1'b1;
      emit     = 1'b1;
      code     = c;
    end
  endtask

  // compare results first, then predict from the word accepted at this edge
  always @(posedge clk) begin
    logic              emit;
    logic              by_escape;
    logic [CHAR_W-1:0] code;
    logic [CHAR_W-1:0] want;
    if (rst) begin
      st = '0;
      expected_chars.delete();
      errors          <= 0;
      pending         <= 0;
      words_seen      <= 0;
      chars_checked   <= 0;
      escapes_emitted <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected out_char %h, nothing expected", $time, out_ch.out_char);
          errors <= errors + 1;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.out_char !== want) begin
            $display("%0t: out_char mismatch, expected %h, actual %h",
                     $time, want, out_ch.out_char);
            errors <= errors + 1;
          end
          chars_checked <= chars_checked + 1;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        filter_word(in_ch.start_of_text, in_ch.in_char, emit, by_escape, code);
        if (emit) expected_chars = {expected_chars, code};
        if (emit && by_escape) escapes_emitted <= escapes_emitted + 1;
        words_seen <= words_seen + 1;
      end
      pending <= expected_chars.size();
    end
  end

endmodule

### sim/rtf_plain_text_filter_top_tb.sv
// rtf_plain_text_filter_top_tb: drives rich-text words into the filter with
// random gaps and stalls, and gives the verdict from rtf_filter_checker
// depends on rtf_pkg, rtf_in_if, rtf_out_if, rtf_plain_text_filter_top

module rtf_plain_text_filter_top_tb;
  import rtf_pkg::*;

  localparam int RANDOM_WORDS = 1550;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 600;
  localparam int STEADY_FROM  = 1000;
  localparam int STEADY_TO    = 1250;
  localparam int IDLE_PCT     = 24;

  typedef struct {
    logic              sot;
    logic [CHAR_W-1:0] ch;
  } text_word_t;

  logic clk;
  logic rst;

  rtf_in_if  in_ch ();
  rtf_out_if out_ch ();

  int chk_errors, chk_pending, chk_words, chk_chars, chk_escapes;

  rtf_plain_text_filter_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rtf_filter_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .errors          (chk_errors),
    .pending         (chk_pending),
    .words_seen      (chk_words),
    .chars_checked   (chk_chars),
    .escapes_emitted (chk_escapes)
  );

  text_word_t text_words [$];
  logic       new_text;
  int         texts;
  int         words_sent;
  int         hold_left;
  logic       hold_done;
  int         idle_cycles;
  logic       steady;

  assign steady = (words_sent >= STEADY_FROM) && (words_sent < STEADY_TO);

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // queue one word, flagging the first word of a new text
  function automatic void add_word(input logic [CHAR_W-1:0] ch);
    text_word_t w;
    w.sot = new_text;
    w.ch  = ch;
    if (new_text) texts++;
    new_text = 1'b0;
    text_words = {text_words, w};
  endfunction

  function automatic logic [CHAR_W-1:0] pick_hex_digit();
    case ($urandom_range(2))
      0:       return CHAR_W'(16'h0030 + $urandom_range(9));
      1:       return CHAR_W'(16'h0061 + $urandom_range(5));
      default: return CHAR_W'(16'h0041 + $urandom_range(5));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_special();
    case ($urandom_range(6))
      0:       return CH_BACKSLASH;
      1:       return CH_APOS;
      2:       return CH_SPACE;
      3:       return CH_CR;
      4:       return CH_LF;
      5:       return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // any code unit, weighted toward ascii and the characters the parse cares about
  function automatic logic [CHAR_W-1:0] pick_any();
    case ($urandom_range(3))
      0:       return CHAR_W'($urandom_range(16'hFFFF));
      1:       return CHAR_W'(16'h0021 + $urandom_range(16'h5D));
      2:       return pick_special();
      default: return CHAR_W'(16'h0061 + $urandom_range(25));
    endcase
  endfunction

  // mostly printable text that does not start markup
  function automatic logic [CHAR_W-1:0] pick_text_char();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(7) == 0) c = CHAR_W'($urandom_range(16'hFFFF));
    else c = CHAR_W'(16'h0021 + $urandom_range(16'h5D));
    if (c == CH_BACKSLASH || c == CH_LBRACE || c == CH_RBRACE) c = 16'h0078;
    return c;
  endfunction

  function automatic void add_ansi_word();
    add_word(CH_BACKSLASH);
    add_word(16'h0061);
    add_word(16'h006E);
    add_word(16'h0073);
    add_word(16'h0069);
  endfunction

  // directed opening: blanks before text, extremes, braces, ansi and escapes
  function automatic void add_directed();
    new_text = 1'b1;
    add_word(CH_SPACE);
    add_word(CH_CR);
    add_word(CH_LF);
    add_word(16'h0000);
    add_word(16'hFFFF);
    add_word(CH_LBRACE);
    add_word(16'h0078);
    add_word(CH_RBRACE);
    add_ansi_word();
    // full escape, then one cut short by a non-hex first digit and one by a non-hex second digit
    add_word(CH_BACKSLASH);
    add_word(CH_APOS);
    add_word(16'h0034);
    add_word(16'h0046);
    add_word(CH_BACKSLASH);
    add_word(CH_APOS);
    add_word(16'h0067);
    add_word(16'h0031);
    add_word(CH_LBRACE);
    add_word(CH_BACKSLASH);
    add_word(CH_APOS);
    add_word(16'h0063);
    add_word(16'h007A);
    add_word(CH_RBRACE);
    add_word(CH_SPACE);
  endfunction

  // one random piece of rich text
  function automatic void add_segment();
    int n;
    if ($urandom_range(11) == 0) begin
      new_text = 1'b1;
      if ($urandom_range(3) != 0) begin
        add_ansi_word();
        add_word(pick_blank());
      end
    end
    case ($urandom_range(11))
      0, 1, 2: repeat ($urandom_range(1, 4)) add_word(pick_text_char());
      3: add_word(pick_blank());
      // control word with a terminator or running into the next piece
      4, 5: begin
        add_word(CH_BACKSLASH);
        repeat ($urandom_range(1, 5)) add_word(CHAR_W'(16'h0061 + $urandom_range(25)));
        n = $urandom_range(5);
        if (n < 3) add_word(pick_blank());
        else if (n == 3) add_word(CH_LBRACE);
        else if (n == 4) add_word(CH_RBRACE);
      end
      6: begin
        add_word(CH_LBRACE);
        repeat ($urandom_range(0, 4)) add_word(pick_any());
        add_word(CH_RBRACE);
      end
      // hex escape, mostly with good digits
      7, 8: begin
        add_word(CH_BACKSLASH);
        add_word(CH_APOS);
        add_word(($urandom_range(3) != 0) ? pick_hex_digit() : pick_any());
        add_word(($urandom_range(3) != 0) ? pick_hex_digit() : pick_any());
      end
      9: begin
        add_ansi_word();
        add_word(pick_blank());
      end
      // broken sequences: partial ansi word, or an escape cut by a new text
      10: begin
        add_word(CH_BACKSLASH);
        if ($urandom_range(1) == 0) begin
          n = $urandom_range(1, 3);
          add_word(16'h0061);
          if (n > 1) add_word(16'h006E);
          if (n > 2) add_word(16'h0073);
          add_word(pick_any());
        end else begin
          add_word(CH_APOS);
          if ($urandom_range(1) == 0) add_word(pick_hex_digit());
          new_text = 1'b1;
        end
      end
      default: add_word(pick_any());
    endcase
  endfunction

  // input side: offer words, idling at random outside the steady stretch
  always @(posedge clk) begin
    text_word_t w;
    if (rst) begin
      in_ch.valid         <= 1'b0;
      in_ch.start_of_text <= 1'b0;
      in_ch.in_char       <= '0;
      words_sent          <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) words_sent <= words_sent + 1;
      if (!in_ch.valid || in_ch.ready) begin
        if (text_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          w = text_words.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.start_of_text <= w.sot;
          in_ch.in_char       <= w.ch;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output side: random stalls plus one long hold-off that backs up the input
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && words_sent >= HOLD_AT) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("rtf_plain_text_filter_top_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus build, reset and verdict
  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.start_of_text = 1'b0;
    in_ch.in_char       = '0;
    out_ch.ready        = 1'b0;
    idle_cycles         = 0;
    texts               = 0;
    new_text            = 1'b0;
    add_directed();
    while (text_words.size() < RANDOM_WORDS + 28) add_segment();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // all words accepted, then every expected word back, then drain
    do @(negedge clk); while (text_words.size() != 0 || in_ch.valid);
    while (chk_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run covered %0d input words in %0d texts, %0d plain-text words checked",
             chk_words, texts, chk_chars);
    $display("of those, %0d came from hex escapes; one long output stall was applied",
             chk_escapes);
    if (chk_errors == 0) begin
      $display("rtf_plain_text_filter_top_tb: done, clean");
    end else begin
      $display("rtf_plain_text_filter_top_tb: done, errors");
    end
    $finish;
  end

endmodule
